// ----- rtl/core/tmgr_pkg.sv -----
package tmgr_pkg;

  localparam int SCREEN_WIDTH  = 160;
  localparam int SCREEN_HEIGHT = 128;
  localparam int MARGIN_LEFT   = 4;
  localparam int MARGIN_TOP    = 4;
  localparam int GLYPH_W       = 5;
  localparam int GLYPH_H       = 7;
  localparam int BAND_H        = 8;
  localparam int CELL_W        = 6;
  localparam int TEXT_ROWS     = (SCREEN_HEIGHT - MARGIN_TOP) / BAND_H;
  localparam int TEXT_COLS     = (SCREEN_WIDTH - MARGIN_LEFT) / CELL_W;
  localparam int TEXT_DEPTH    = TEXT_ROWS * TEXT_COLS;
  localparam int ADDR_W        = $clog2(TEXT_DEPTH);

  // field widths of the stream payload
  localparam int ROW_W   = 4;
  localparam int COL_W   = 5;
  localparam int CODE_W  = 8;
  localparam int PX_W    = 8;
  localparam int PY_W    = 7;
  localparam int COLOR_W = 16;

  // divide by CELL_W as multiply and shift, exact for dx below 512
  localparam int DIV6_MUL   = 171;
  localparam int DIV6_SHIFT = 10;

  localparam int GLYPH_IDX_W = 5;
  localparam logic [GLYPH_IDX_W-1:0] GLYPH_DIGIT0   = 5'd18;
  localparam logic [GLYPH_IDX_W-1:0] GLYPH_COLON    = 5'd28;
  localparam logic [GLYPH_IDX_W-1:0] GLYPH_MINUS    = 5'd29;
  localparam logic [GLYPH_IDX_W-1:0] GLYPH_SPACE    = 5'd30;
  localparam logic [GLYPH_IDX_W-1:0] GLYPH_FALLBACK = 5'd31;

  typedef enum logic [1:0] {
    REG_BAND_COUNT = 2'd0,
    REG_FG_COLOR   = 2'd1,
    REG_BG_COLOR   = 2'd2
  } reg_idx_t;

  localparam logic [ROW_W-1:0]   BAND_COUNT_RST = '0;
  localparam logic [COLOR_W-1:0] FG_COLOR_RST   = 16'hffff;
  localparam logic [COLOR_W-1:0] BG_COLOR_RST   = 16'h0000;

  localparam logic [4:0] GLYPH_ROM [0:31][0:6] = '{
    '{5'h0e, 5'h11, 5'h11, 5'h1f, 5'h11, 5'h11, 5'h11}, // A
    '{5'h1e, 5'h11, 5'h11, 5'h1e, 5'h11, 5'h11, 5'h1e}, // B
    '{5'h0e, 5'h11, 5'h10, 5'h10, 5'h10, 5'h11, 5'h0e}, // C
    '{5'h1e, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h1e}, // D
    '{5'h1f, 5'h10, 5'h10, 5'h1e, 5'h10, 5'h10, 5'h1f}, // E
    '{5'h0e, 5'h11, 5'h10, 5'h17, 5'h11, 5'h11, 5'h0f}, // G
    '{5'h11, 5'h11, 5'h11, 5'h1f, 5'h11, 5'h11, 5'h11}, // H
    '{5'h1f, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h1f}, // I
    '{5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h1f}, // L
    '{5'h11, 5'h1b, 5'h15, 5'h15, 5'h11, 5'h11, 5'h11}, // M
    '{5'h11, 5'h19, 5'h15, 5'h13, 5'h11, 5'h11, 5'h11}, // N
    '{5'h0e, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0e}, // O
    '{5'h1e, 5'h11, 5'h11, 5'h1e, 5'h10, 5'h10, 5'h10}, // P
    '{5'h1e, 5'h11, 5'h11, 5'h1e, 5'h14, 5'h12, 5'h11}, // R
    '{5'h0f, 5'h10, 5'h10, 5'h0e, 5'h01, 5'h01, 5'h1e}, // S
    '{5'h1f, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04}, // T
    '{5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0e}, // U
    '{5'h11, 5'h11, 5'h0a, 5'h04, 5'h04, 5'h04, 5'h04}, // Y
    '{5'h0e, 5'h11, 5'h13, 5'h15, 5'h19, 5'h11, 5'h0e}, // 0
    '{5'h04, 5'h0c, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0e}, // 1
    '{5'h0e, 5'h11, 5'h01, 5'h02, 5'h04, 5'h08, 5'h1f}, // 2
    '{5'h1e, 5'h01, 5'h01, 5'h0e, 5'h01, 5'h01, 5'h1e}, // 3
    '{5'h02, 5'h06, 5'h0a, 5'h12, 5'h1f, 5'h02, 5'h02}, // 4
    '{5'h1f, 5'h10, 5'h10, 5'h1e, 5'h01, 5'h01, 5'h1e}, // 5
    '{5'h0e, 5'h10, 5'h10, 5'h1e, 5'h11, 5'h11, 5'h0e}, // 6
    '{5'h1f, 5'h01, 5'h02, 5'h04, 5'h08, 5'h08, 5'h08}, // 7
    '{5'h0e, 5'h11, 5'h11, 5'h0e, 5'h11, 5'h11, 5'h0e}, // 8
    '{5'h0e, 5'h11, 5'h11, 5'h0f, 5'h01, 5'h01, 5'h0e}, // 9
    '{5'h00, 5'h04, 5'h04, 5'h00, 5'h04, 5'h04, 5'h00}, // colon
    '{5'h00, 5'h00, 5'h00, 5'h1f, 5'h00, 5'h00, 5'h00}, // minus
    '{5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00}, // space
    '{5'h1f, 5'h11, 5'h05, 5'h02, 5'h04, 5'h00, 5'h04}  // fallback
  };

  function automatic logic [GLYPH_IDX_W-1:0] glyph_select(input logic [CODE_W-1:0] code);
    logic [CODE_W-1:0]      up;
    logic [GLYPH_IDX_W-1:0] idx;
    begin
      up = code;
      if (code >= "a" && code <= "z") begin
        up = code - 8'd32;
      end
      case (up)
        "A": idx = 5'd0;
        "B": idx = 5'd1;
        "C": idx = 5'd2;
        "D": idx = 5'd3;
        "E": idx = 5'd4;
        "G": idx = 5'd5;
        "H": idx = 5'd6;
        "I": idx = 5'd7;
        "L": idx = 5'd8;
        "M": idx = 5'd9;
        "N": idx = 5'd10;
        "O": idx = 5'd11;
        "P": idx = 5'd12;
        "R": idx = 5'd13;
        "S": idx = 5'd14;
        "T": idx = 5'd15;
        "U": idx = 5'd16;
        "Y": idx = 5'd17;
        ":": idx = GLYPH_COLON;
        "-": idx = GLYPH_MINUS;
        " ": idx = GLYPH_SPACE;
        default: begin
          if (up >= "0" && up <= "9") begin
            idx = GLYPH_DIGIT0 + GLYPH_IDX_W'(up - "0");
          end else begin
            idx = GLYPH_FALLBACK;
          end
        end
      endcase
      return idx;
    end
  endfunction

  // glyph row bits, bit 4 is the leftmost column; the eighth band line is blank
  function automatic logic [GLYPH_W-1:0] glyph_bits(input logic [GLYPH_IDX_W-1:0] idx,
                                                    input logic [2:0] grow);
    logic [GLYPH_W-1:0] bits;
    begin
      bits = '0;
      if (32'(grow) < GLYPH_H) begin
        bits = GLYPH_ROM[idx][grow];
      end
      return bits;
    end
  endfunction

endpackage

// ----- rtl/core/tmgr_ram.sv -----
module tmgr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 390
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/core/text_mode_glyph_renderer_top.sv -----
// 5x7 text overlay character generator. Requests on the s_ stream carry a kind bit in
// s_tuser: 0 stores char_code at (char_row, text_col) of a 15 x 26 text memory and gives
// no result, 1 asks for the RGB565 colour of pixel (pixel_x, pixel_y) and gives one
// result on the m_ stream, with m_tuser high when the pixel lies in a drawn text band.
// A request is taken in every cycle while the result side keeps up; s_tready drops only
// while a result is held at the output and another pixel request waits behind it. A
// pixel request's text memory read is registered at the accepting edge, and the glyph
// lookup fills the output register once that register is empty or being taken. A write
// is visible to any pixel request taken after it. String lengths are cleared by reset,
// the text memory is not; band_count, fg_color and bg_color sit at APB byte addresses
// 0, 4 and 8, to be written while the block is idle; the block does not enforce this.
module text_mode_glyph_renderer_top
  import tmgr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // apb configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // requests
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,  // char_row[3:0], text_col[8:4], char_code[16:9],
                                // pixel_x[24:17], pixel_y[31:25]
  input  logic        s_tuser,  // op
  // pixel results
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,  // color[15:0]
  output logic        m_tuser   // drawn
);

  logic [ROW_W-1:0]   band_count;
  logic [COLOR_W-1:0] fg_color;
  logic [COLOR_W-1:0] bg_color;
  logic               cfg_wr;
  reg_idx_t           reg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_idx = reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      band_count <= BAND_COUNT_RST;
      fg_color   <= FG_COLOR_RST;
      bg_color   <= BG_COLOR_RST;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_BAND_COUNT: band_count <= pwdata[ROW_W-1:0];
        REG_FG_COLOR:   fg_color   <= pwdata[COLOR_W-1:0];
        REG_BG_COLOR:   bg_color   <= pwdata[COLOR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_BAND_COUNT: prdata = 32'(band_count);
      REG_FG_COLOR:   prdata = 32'(fg_color);
      REG_BG_COLOR:   prdata = 32'(bg_color);
      default:        prdata = '0;
    endcase
  end

  // request fields
  logic [ROW_W-1:0]  in_row;
  logic [COL_W-1:0]  in_col;
  logic [CODE_W-1:0] in_code;
  logic [PX_W-1:0]   in_x;
  logic [PY_W-1:0]   in_y;

  assign in_row  = s_tdata[3:0];
  assign in_col  = s_tdata[8:4];
  assign in_code = s_tdata[16:9];
  assign in_x    = s_tdata[24:17];
  assign in_y    = s_tdata[31:25];

  // pipeline control
  logic s1_valid;
  logic s2_load;
  logic accept;
  logic pix_accept;
  logic wr_accept;

  assign s2_load    = s1_valid && (!m_tvalid || m_tready);
  assign s_tready   = !s1_valid || s2_load;
  assign accept     = s_tvalid && s_tready;
  assign pix_accept = accept && s_tuser;
  assign wr_accept  = accept && !s_tuser;

  // pixel geometry
  logic [3:0]     rows;
  logic [PY_W-1:0] dy;
  logic [ROW_W-1:0] pix_row;
  logic [2:0]     pix_grow;
  logic [PX_W-1:0] dx;
  logic [15:0]    dx_mul;
  logic [5:0]     pix_col;
  logic [2:0]     pix_gx;
  logic           in_band;
  logic           in_glyph;

  assign rows     = (32'(band_count) > TEXT_ROWS) ? ROW_W'(TEXT_ROWS) : band_count;
  assign dy       = in_y - PY_W'(MARGIN_TOP);
  assign pix_row  = dy[PY_W-1:3];
  assign pix_grow = dy[2:0];
  assign dx       = in_x - PX_W'(MARGIN_LEFT);
  assign dx_mul   = 16'(dx) * 16'(DIV6_MUL);
  assign pix_col  = dx_mul[DIV6_SHIFT +: 6];
  assign pix_gx   = 3'(dx - PX_W'(pix_col) * PX_W'(CELL_W));

  assign in_band = (32'(in_x) < SCREEN_WIDTH) && (32'(in_y) < SCREEN_HEIGHT)
                   && (32'(in_y) >= MARGIN_TOP) && (pix_row < rows);

  // string lengths, one read port shared by both request kinds
  logic [COL_W-1:0] row_end [TEXT_ROWS];
  logic [ROW_W-1:0] re_row;
  logic [COL_W-1:0] re_cur;
  logic [COL_W-1:0] re_next;
  logic             wr_in_range;

  assign re_row = s_tuser ? pix_row : in_row;
  assign re_cur = (32'(re_row) < TEXT_ROWS) ? row_end[re_row] : '0;

  assign in_glyph = (32'(pix_grow) < GLYPH_H) && (32'(in_x) >= MARGIN_LEFT)
                    && (32'(pix_gx) < GLYPH_W) && (32'(pix_col) < TEXT_COLS)
                    && (pix_col < 6'(re_cur));

  assign wr_in_range = (32'(in_row) < TEXT_ROWS) && (32'(in_col) < TEXT_COLS);

  always_comb begin
    re_next = re_cur;
    if (in_code == '0) begin
      if (in_col < re_cur) begin
        re_next = in_col;
      end
    end else if (in_col == '0) begin
      re_next = COL_W'(1);
    end else if (in_col == re_cur) begin
      re_next = in_col + COL_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < TEXT_ROWS; i++) begin
        row_end[i] <= '0;
      end
    end else if (wr_accept && wr_in_range) begin
      row_end[in_row] <= re_next;
    end
  end

  // text memory
  logic [ADDR_W-1:0] waddr;
  logic [ADDR_W-1:0] raddr;
  logic [CODE_W-1:0] cell_code;

  assign waddr = ADDR_W'(in_row) * ADDR_W'(TEXT_COLS) + ADDR_W'(in_col);
  assign raddr = (in_band && in_glyph)
                 ? ADDR_W'(pix_row) * ADDR_W'(TEXT_COLS) + ADDR_W'(pix_col)
                 : '0;

  tmgr_ram #(
    .WIDTH (CODE_W),
    .DEPTH (TEXT_DEPTH)
  ) u_text_ram (
    .clk   (clk),
    .we    (wr_accept && wr_in_range),
    .waddr (waddr),
    .wdata (in_code),
    .re    (pix_accept),
    .raddr (raddr),
    .rdata (cell_code)
  );

  // stage 1: cell code arrives from the memory
  logic       s1_drawn;
  logic       s1_lit;
  logic [2:0] s1_grow;
  logic [2:0] s1_gx;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_tready) begin
      s1_valid <= pix_accept;
    end
  end

  always_ff @(posedge clk) begin
    if (pix_accept) begin
      s1_drawn <= in_band;
      s1_lit   <= in_band && in_glyph;
      s1_grow  <= pix_grow;
      s1_gx    <= pix_gx;
    end
  end

  // stage 2: glyph lookup into the output register
  logic [GLYPH_W-1:0]  gbits;
  logic                gpix;
  logic [COLOR_W-1:0]  color_next;

  assign gbits = glyph_bits(glyph_select(cell_code), s1_grow);
  assign gpix  = gbits[3'(GLYPH_W - 1) - s1_gx];

  always_comb begin
    color_next = '0;
    if (s1_drawn) begin
      color_next = (s1_lit && gpix) ? fg_color : bg_color;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s2_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_load) begin
      m_tdata <= color_next;
      m_tuser <= s1_drawn;
    end
  end

endmodule
